// ===== rtl/core/ir_pulse_distance_sender_assert.svh =====
// assertion macros for the infrared pulse-distance sender
// no dependencies; included by the top level before its module header
`ifndef IR_PULSE_DISTANCE_SENDER_ASSERT_SVH
`define IR_PULSE_DISTANCE_SENDER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define IRPDS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define IRPDS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/irpds_pkg.sv =====
// shared types and constants of the infrared pulse-distance sender
// no dependencies
`default_nettype none

package irpds_pkg;

    // field widths
    localparam int unsigned CODE_W  = 32;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned LEN_W   = 8;
    localparam int unsigned CAR_W   = 5;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CFG_IDX_W = 3;

    // frame phases
    localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEAD_MARK  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEAD_SPACE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_BIT_MARK   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_BIT_SPACE  = 3'd4;

    // request commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_PERIOD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_HIGH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_LOW  = 3'd7;

    // register reset values
    localparam logic [LEN_W-1:0] RST_LEADER_MARK  = 8'd176;
    localparam logic [LEN_W-1:0] RST_LEADER_SPACE = 8'd88;
    localparam logic [LEN_W-1:0] RST_BIT_MARK     = 8'd11;
    localparam logic [LEN_W-1:0] RST_ZERO_PERIOD  = 8'd22;
    localparam logic [LEN_W-1:0] RST_ONE_PERIOD   = 8'd44;
    localparam logic [LEN_W-1:0] RST_PRESCALE     = 8'd51;
    localparam logic [CAR_W-1:0] RST_CARRIER_HIGH = 5'd9;
    localparam logic [CAR_W-1:0] RST_CARRIER_LOW  = 5'd17;

    localparam logic [LEN_W-1:0] UNIT_MAX = 8'd255;

    typedef struct packed {
        logic ir_out;
        logic mark_active;
        logic busy_res;
        logic frame_done;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/irpds_req_if.sv =====
// request channel of the infrared pulse-distance sender
// depends on irpds_pkg for field widths
`default_nettype none

interface irpds_req_if;
    import irpds_pkg::*;

    logic               valid;
    logic               ready;
    logic               command;
    logic [CODE_W-1:0]  code_word;
    logic [COUNT_W-1:0] bit_count;

    modport source (output valid, command, code_word, bit_count, input ready);
    modport sink   (input valid, command, code_word, bit_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/irpds_res_if.sv =====
// result channel of the infrared pulse-distance sender
// no dependencies
`default_nettype none

interface irpds_res_if;
    logic valid;
    logic ready;
    logic ir_out;
    logic mark_active;
    logic busy_res;
    logic frame_done;

    modport source (output valid, ir_out, mark_active, busy_res, frame_done, input ready);
    modport sink   (input valid, ir_out, mark_active, busy_res, frame_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ir_pulse_distance_sender.sv =====
// infrared pulse-distance sender: one registered result per request
// one request per cycle while no result waits; output register frees as taken
// the frame state update is a single combinational step per base tick
// reset (i_rst_n, synchronous, active low) restores the default timing
// registers, returns the sender to idle and empties the output register
// depends on irpds_pkg, irpds_req_if, irpds_res_if and the assertion header
`default_nettype none
`include "ir_pulse_distance_sender_assert.svh"

module ir_pulse_distance_sender #(
    parameter int MAX_BITS = 32
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    irpds_req_if.sink                      i_req,
    irpds_res_if.source                    o_res,
    input  wire                            i_cfg_we,
    input  wire [irpds_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [irpds_pkg::LEN_W-1:0]     i_cfg_data
);
    import irpds_pkg::*;

    // bits left has to hold the largest frame length itself
    localparam int unsigned BL_W = $clog2(MAX_BITS + 1);

    // timing registers
    logic [LEN_W-1:0] r_leader_mark_len, r_leader_space_len, r_bit_mark_len;
    logic [LEN_W-1:0] r_zero_period, r_one_period, r_unit_prescale;
    logic [CAR_W-1:0] r_carrier_high, r_carrier_low;

    // frame state
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CODE_W-1:0]  r_shift_word, n_shift_word;
    logic [BL_W-1:0]    r_bits_left, n_bits_left;
    logic [LEN_W-1:0]   r_prescale_count, n_prescale_count;
    logic [LEN_W-1:0]   r_unit_count, n_unit_count;
    logic [CAR_W-1:0]   r_carrier_count, n_carrier_count;
    logic               r_carrier_level, n_carrier_level;

    // output register
    logic    r_res_valid;
    t_result r_res, n_res;

    logic             req_accept;
    logic             res_accept;
    logic [CAR_W-1:0] carrier_next;
    logic [LEN_W-1:0] prescale_next;
    logic [LEN_W-1:0] prescale_eff;
    logic [LEN_W-1:0] unit_next;
    logic [LEN_W-1:0] period;
    logic [BL_W-1:0]  bits_dec;
    logic             in_mark;

    // the output register may be refilled in the cycle its contents are taken
    assign i_req.ready = !r_res_valid || o_res.ready;
    assign req_accept  = i_req.valid && i_req.ready;
    assign res_accept  = r_res_valid && o_res.ready;

    assign o_res.valid       = r_res_valid;
    assign o_res.ir_out      = r_res.ir_out;
    assign o_res.mark_active = r_res.mark_active;
    assign o_res.busy_res    = r_res.busy_res;
    assign o_res.frame_done  = r_res.frame_done;

    // ---------------------------------------------------------------
    // configuration writes, taken at once
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader_mark_len  <= RST_LEADER_MARK;
            r_leader_space_len <= RST_LEADER_SPACE;
            r_bit_mark_len     <= RST_BIT_MARK;
            r_zero_period      <= RST_ZERO_PERIOD;
            r_one_period       <= RST_ONE_PERIOD;
            r_unit_prescale    <= RST_PRESCALE;
            r_carrier_high     <= RST_CARRIER_HIGH;
            r_carrier_low      <= RST_CARRIER_LOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LEADER_MARK:  r_leader_mark_len  <= i_cfg_data;
                REG_LEADER_SPACE: r_leader_space_len <= i_cfg_data;
                REG_BIT_MARK:     r_bit_mark_len     <= i_cfg_data;
                REG_ZERO_PERIOD:  r_zero_period      <= i_cfg_data;
                REG_ONE_PERIOD:   r_one_period       <= i_cfg_data;
                REG_PRESCALE:     r_unit_prescale    <= i_cfg_data;
                REG_CARRIER_HIGH: r_carrier_high     <= i_cfg_data[CAR_W-1:0];
                REG_CARRIER_LOW:  r_carrier_low      <= i_cfg_data[CAR_W-1:0];
                default:          r_carrier_low      <= r_carrier_low;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // per-tick timing terms
    // ---------------------------------------------------------------
    assign in_mark       = (r_phase == PH_LEAD_MARK) || (r_phase == PH_BIT_MARK);
    assign carrier_next  = r_carrier_count + 1'b1;
    // a zero prescale counts as one tick per unit
    assign prescale_eff  = (r_unit_prescale == '0) ? LEN_W'(1) : r_unit_prescale;
    assign prescale_next = r_prescale_count + 1'b1;
    assign unit_next     = (prescale_next >= prescale_eff && r_unit_count != UNIT_MAX)
                           ? r_unit_count + 1'b1 : r_unit_count;
    // bit length follows the bit currently at the bottom of the shift word
    assign period        = r_shift_word[0] ? r_one_period : r_zero_period;
    assign bits_dec      = r_bits_left - 1'b1;

    // ---------------------------------------------------------------
    // next frame state and result for the accepted request
    // ---------------------------------------------------------------
    always_comb begin
        n_phase          = r_phase;
        n_shift_word     = r_shift_word;
        n_bits_left      = r_bits_left;
        n_prescale_count = r_prescale_count;
        n_unit_count     = r_unit_count;
        n_carrier_count  = r_carrier_count;
        n_carrier_level  = r_carrier_level;
        n_res            = '0;

        if (i_req.command == CMD_START) begin
            // a start while a frame is running leaves the frame alone
            n_res.busy_res = 1'b1;
            if (r_phase == PH_IDLE) begin
                n_shift_word = i_req.code_word;
                if (int'(i_req.bit_count) > MAX_BITS) begin
                    n_bits_left = BL_W'(MAX_BITS);
                end else begin
                    n_bits_left = BL_W'(i_req.bit_count);
                end
                n_phase          = PH_LEAD_MARK;
                n_prescale_count = '0;
                n_unit_count     = '0;
                n_carrier_count  = '0;
                n_carrier_level  = 1'b1;
            end
        end else if (r_phase != PH_IDLE) begin
            n_res.busy_res    = 1'b1;
            n_res.mark_active = in_mark;
            n_res.ir_out      = in_mark && r_carrier_level;

            // carrier runs only inside a mark
            if (in_mark) begin
                if (r_carrier_level ? (carrier_next >= r_carrier_high)
                                    : (carrier_next >= r_carrier_low)) begin
                    n_carrier_level = !r_carrier_level;
                    n_carrier_count = '0;
                end else begin
                    n_carrier_count = carrier_next;
                end
            end

            // unit prescaler
            if (prescale_next >= prescale_eff) begin
                n_prescale_count = '0;
            end else begin
                n_prescale_count = prescale_next;
            end
            n_unit_count = unit_next;

            unique case (r_phase)
                PH_LEAD_MARK: begin
                    if (unit_next >= r_leader_mark_len) begin
                        n_phase          = PH_LEAD_SPACE;
                        n_unit_count     = '0;
                        n_prescale_count = '0;
                    end
                end
                PH_LEAD_SPACE: begin
                    if (unit_next >= r_leader_space_len) begin
                        if (r_bits_left == '0) begin
                            n_phase          = PH_IDLE;
                            n_res.frame_done = 1'b1;
                        end else begin
                            n_phase          = PH_BIT_MARK;
                            n_prescale_count = '0;
                            n_unit_count     = '0;
                            n_carrier_count  = '0;
                            n_carrier_level  = 1'b1;
                        end
                    end
                end
                PH_BIT_MARK, PH_BIT_SPACE: begin
                    // bit mark ends, then the same tick may also end the bit
                    if (r_phase == PH_BIT_SPACE || unit_next >= r_bit_mark_len) begin
                        n_phase = PH_BIT_SPACE;
                        if (unit_next >= period) begin
                            n_shift_word = r_shift_word >> 1;
                            n_bits_left  = bits_dec;
                            if (bits_dec == '0) begin
                                n_phase          = PH_IDLE;
                                n_res.frame_done = 1'b1;
                            end else begin
                                n_phase          = PH_BIT_MARK;
                                n_prescale_count = '0;
                                n_unit_count     = '0;
                                n_carrier_count  = '0;
                                n_carrier_level  = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // state and output registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_shift_word     <= '0;
            r_bits_left      <= '0;
            r_prescale_count <= '0;
            r_unit_count     <= '0;
            r_carrier_count  <= '0;
            r_carrier_level  <= 1'b1;
            r_res_valid      <= 1'b0;
        end else begin
            if (req_accept) begin
                r_phase          <= n_phase;
                r_shift_word     <= n_shift_word;
                r_bits_left      <= n_bits_left;
                r_prescale_count <= n_prescale_count;
                r_unit_count     <= n_unit_count;
                r_carrier_count  <= n_carrier_count;
                r_carrier_level  <= n_carrier_level;
                r_res_valid      <= 1'b1;
            end else if (res_accept) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_res <= n_res;
        end
    end

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `IRPDS_ASSERT_NOW(a_ir_inside_mark, i_clk, i_rst_n,
        r_res_valid && r_res.ir_out, r_res.mark_active, "carrier outside a mark")
    `IRPDS_ASSERT_NOW(a_done_while_busy, i_clk, i_rst_n,
        r_res_valid && r_res.frame_done, r_res.busy_res, "frame end without busy")
    `IRPDS_ASSERT_NEXT(a_done_to_idle, i_clk, i_rst_n,
        req_accept && n_res.frame_done, r_phase == PH_IDLE, "frame end left sender active")
    `IRPDS_ASSERT_NEXT(a_idle_tick_quiet, i_clk, i_rst_n,
        req_accept && r_phase == PH_IDLE && i_req.command == CMD_TICK,
        !r_res.busy_res && !r_res.mark_active, "idle tick reported activity")
    `IRPDS_ASSERT_NOW(a_bits_bounded, i_clk, i_rst_n,
        r_phase != PH_IDLE, int'(r_bits_left) <= MAX_BITS, "bit count above maximum")

endmodule

`default_nettype wire
